FILE: rtl/vfc_pkg.sv
`timescale 1ns / 1ps

package vfc_pkg;

    // Face geometry and block id codes.
    localparam int unsigned NUM_FACES    = 6;
    localparam int unsigned FACE_W       = 3;
    localparam int unsigned ID_W         = 8;
    localparam int unsigned TEX_W        = 8;
    localparam logic [FACE_W-1:0] FACE_TOP = 3'd5;
    localparam logic [ID_W-1:0] AIR_ID       = 8'd0;
    localparam logic [ID_W-1:0] WATER_ID     = 8'd4;
    localparam logic [ID_W-1:0] PLAIN_MAX_ID = 8'd40;
    localparam logic [ID_W-1:0] SPECIAL_BASE = 8'd41;

    // Input kind carried on tuser.
    localparam logic CMD_CLASSIFY  = 1'b0;
    localparam logic CMD_TABLE_WR  = 1'b1;

    typedef logic [NUM_FACES-1:0][TEX_W-1:0] face_tex_t;

    // One classified voxel handed to the face emitter.
    typedef struct packed {
        logic [5:0]           x;
        logic [7:0]           y;
        logic [5:0]           z;
        logic [NUM_FACES-1:0] mask;
        face_tex_t            tex;
        logic                 is_water;
    } face_set_t;

endpackage

FILE: rtl/voxel_face_culler.sv
`timescale 1ns / 1ps
// A voxel passes stage one and stage two; the emitter registers then drive its faces.
// One item per cycle while m_tready is high and each voxel gives at most one face;
// a voxel's n visible faces (up to six) leave the single-output face emitter in turn.
// Reset (aresetn low, synchronous) clears all valid bits, the face emitter and the
// special texture valid flags, so every special texture reads as zero until written.

module voxel_face_culler #(
    parameter int unsigned SPECIAL_ROWS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, pos_z, block_id, neighbor_blocks, neighbor_present,
    // table_face, table_texture
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // face_x, face_y, face_z, face_dir, texture
    output logic        m_tuser,   // is_water
    output logic        m_tlast
);
    import vfc_pkg::*;

    localparam int unsigned ROW_W = (SPECIAL_ROWS > 1) ? $clog2(SPECIAL_ROWS) : 1;

    // Stage one: accepted item.
    logic        v1_reg;
    logic        cmd1_reg;
    logic [95:0] data1_reg;

    // Stage two: classify fields, table row read under way.
    logic                  v2_reg;
    logic [5:0]            x2_reg;
    logic [7:0]            y2_reg;
    logic [5:0]            z2_reg;
    logic [ID_W-1:0]       id2_reg;
    logic [47:0]           nb2_reg;
    logic [NUM_FACES-1:0]  pres2_reg;
    logic                  row_ok2_reg;

    logic [ID_W-1:0]       id1;
    logic [ID_W-1:0]       diff1;
    logic                  row_ok1;
    logic [ROW_W-1:0]      row1;
    logic [FACE_W-1:0]     tface1;
    logic                  wr_en;
    logic                  rd_en;
    logic                  advance1;
    logic                  s2_free;
    logic                  emit_ready;
    logic                  emit_load;
    face_tex_t             tbl_data;
    logic [NUM_FACES-1:0]  tbl_valid;
    logic [NUM_FACES-1:0]  mask2;
    face_set_t             set2;

    // Special table row decode for the item in stage one.
    assign id1     = data1_reg[27:20];
    assign tface1  = data1_reg[84:82];
    assign diff1   = id1 - SPECIAL_BASE;
    assign row_ok1 = (id1 >= SPECIAL_BASE) && (32'(diff1) < 32'(SPECIAL_ROWS));
    assign row1    = row_ok1 ? diff1[ROW_W-1:0] : '0;

    assign advance1 = v1_reg && s2_free;
    assign s_tready = !v1_reg || s2_free;
    assign wr_en    = advance1 && (cmd1_reg == CMD_TABLE_WR) && row_ok1
                      && (32'(tface1) < NUM_FACES);
    assign rd_en    = advance1 && (cmd1_reg == CMD_CLASSIFY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd1_reg  <= s_tuser;
            data1_reg <= s_tdata;
        end
    end

    vfc_table #(
        .SPECIAL_ROWS (SPECIAL_ROWS),
        .ROW_W        (ROW_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_row   (row1),
        .wr_face  (tface1),
        .wr_data  (data1_reg[92:85]),
        .rd_en    (rd_en),
        .rd_row   (row1),
        .rd_data  (tbl_data),
        .rd_valid (tbl_valid)
    );

    // Stage two registers; table writes are consumed here and go no further.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (s2_free) begin
            v2_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            x2_reg      <= data1_reg[5:0];
            y2_reg      <= data1_reg[13:6];
            z2_reg      <= data1_reg[19:14];
            id2_reg     <= id1;
            nb2_reg     <= data1_reg[75:28];
            pres2_reg   <= data1_reg[81:76];
            row_ok2_reg <= row_ok1;
        end
    end

    // Visibility: solids show faces to air or water, water only its top face to air.
    always_comb begin
        mask2 = '0;
        if (id2_reg == WATER_ID) begin
            mask2[FACE_TOP] = pres2_reg[FACE_TOP] && (nb2_reg[47:40] == AIR_ID);
        end else if (id2_reg != AIR_ID) begin
            for (int j = 0; j < NUM_FACES; j++) begin
                mask2[j] = pres2_reg[j]
                           && ((nb2_reg[8*j +: 8] | WATER_ID) == WATER_ID);
            end
        end
    end

    // Texture per face: the id itself, or the special table entry.
    always_comb begin
        set2.x        = x2_reg;
        set2.y        = y2_reg;
        set2.z        = z2_reg;
        set2.mask     = mask2;
        set2.is_water = (id2_reg == WATER_ID);
        for (int j = 0; j < NUM_FACES; j++) begin
            if (id2_reg <= PLAIN_MAX_ID) begin
                set2.tex[j] = id2_reg;
            end else if (row_ok2_reg && tbl_valid[j]) begin
                set2.tex[j] = tbl_data[j];
            end else begin
                set2.tex[j] = '0;
            end
        end
    end

    // A voxel without visible faces leaves stage two without waiting.
    assign s2_free   = !v2_reg || (mask2 == '0) || emit_ready;
    assign emit_load = v2_reg && (mask2 != '0) && emit_ready;

    vfc_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit_load),
        .load_set (set2),
        .ready    (emit_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/vfc_table.sv
`timescale 1ns / 1ps

module vfc_table #(
    parameter int unsigned SPECIAL_ROWS = 16,
    parameter int unsigned ROW_W        = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [ROW_W-1:0]            wr_row,
    input  logic [vfc_pkg::FACE_W-1:0]  wr_face,
    input  logic [vfc_pkg::TEX_W-1:0]   wr_data,
    input  logic                        rd_en,
    input  logic [ROW_W-1:0]            rd_row,
    output vfc_pkg::face_tex_t          rd_data,
    output logic [vfc_pkg::NUM_FACES-1:0] rd_valid
);
    import vfc_pkg::*;

    face_tex_t                                 mem [SPECIAL_ROWS];
    logic [SPECIAL_ROWS-1:0][NUM_FACES-1:0]    valid_reg;
    face_tex_t                                 rd_data_reg;
    logic [NUM_FACES-1:0]                      rd_valid_reg;

    // Texture memory: one entry written, one row read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_face] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    // Entry valid bits; an entry never written reads as zero texture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_row][wr_face] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_row];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

FILE: rtl/vfc_emitter.sv
`timescale 1ns / 1ps

module vfc_emitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  vfc_pkg::face_set_t         load_set,
    output logic                       ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // face_x, face_y, face_z, face_dir, texture
    output logic                       m_tuser,   // is_water
    output logic                       m_tlast
);
    import vfc_pkg::*;

    face_set_t            set_reg;
    logic [NUM_FACES-1:0] mask_reg;
    logic [NUM_FACES-1:0] mask_next;
    logic [FACE_W-1:0]    dir;
    logic                 busy;
    logic                 last_face;
    logic                 take;

    // Lowest remaining face goes out first.
    always_comb begin
        dir = '0;
        for (int j = NUM_FACES - 1; j >= 0; j--) begin
            if (mask_reg[j]) begin
                dir = FACE_W'(j);
            end
        end
    end

    assign busy      = |mask_reg;
    assign last_face = (mask_reg & (mask_reg - NUM_FACES'(1))) == '0;
    assign take      = busy && m_tready;
    assign ready     = !busy || (m_tready && last_face);

    // Remaining faces once the current one has been taken.
    always_comb begin
        mask_next = mask_reg;
        if (take) begin
            mask_next = mask_reg & (mask_reg - NUM_FACES'(1));
        end
        if (load) begin
            mask_next = load_set.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            set_reg <= load_set;
        end
    end

    assign m_tvalid = busy;
    assign m_tdata  = {1'b0, set_reg.tex[dir], dir, set_reg.z, set_reg.y, set_reg.x};
    assign m_tuser  = set_reg.is_water;
    assign m_tlast  = last_face;

endmodule
